/* sv/efr_pkg.sv */
// Shared types, widths and codes for the edge-function triangle rasterizer.
// No dependencies; every other file of the block imports this package.
package efr_pkg;

  localparam int SUBPIXEL_BITS = 4;
  localparam int MAX_DIMENSION = 2048;

  localparam int COORD_W   = 16;
  localparam int CFG_W     = 12;
  localparam int CFG_IDX_W = 1;
  localparam int BOX_W     = $clog2(MAX_DIMENSION + 1);
  localparam int DIFF_W    = COORD_W + 1;
  localparam int STEP_W    = DIFF_W + SUBPIXEL_BITS;
  localparam int AREA_W    = 2 * DIFF_W;
  localparam int MUL_A_W   = (DIFF_W > BOX_W + 1) ? DIFF_W : BOX_W + 1;
  localparam int PROD_W    = MUL_A_W + STEP_W;
  localparam int EDGE_W    = 42;
  localparam int MAC_W     = AREA_W + 8;
  localparam int NUM_W     = MAC_W + 2;
  localparam int QUAD_LOG  = SUBPIXEL_BITS + 1;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [CFG_W-1:0] SURF_W_RESET = CFG_W'(640);
  localparam logic [CFG_W-1:0] SURF_H_RESET = CFG_W'(480);

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_HEIGHT = 1'b1;

  typedef enum logic {
    OP_LOAD,
    OP_NEXT
  } efr_op_t;

  typedef enum logic [1:0] {
    STATUS_ACCEPTED,
    STATUS_CULLED,
    STATUS_QUAD,
    STATUS_DONE
  } efr_status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_AREA,
    S_SETUP,
    S_EDGE,
    S_SCAN,
    S_MAC,
    S_DIV_GO,
    S_DIV_WAIT,
    S_EMIT
  } efr_state_t;

  typedef struct packed {
    logic               kind;
    logic signed [15:0] vert0_x;
    logic signed [15:0] vert0_y;
    logic signed [15:0] vert1_x;
    logic signed [15:0] vert1_y;
    logic signed [15:0] vert2_x;
    logic signed [15:0] vert2_y;
    logic [31:0]        vert0_colour;
    logic [31:0]        vert1_colour;
    logic [31:0]        vert2_colour;
  } efr_in_t;

  typedef struct packed {
    efr_status_t status;
    logic [10:0] quad_x;
    logic [10:0] quad_y;
    logic [3:0]  coverage;
    logic [31:0] colour_tl;
    logic [31:0] colour_tr;
    logic [31:0] colour_bl;
    logic [31:0] colour_br;
  } efr_out_t;

  typedef struct packed {
    efr_op_t op;
    efr_in_t item;
  } efr_qent_t;

  typedef struct packed {
    logic      valid;
    efr_qent_t ent;
  } efr_q_t;

endpackage

/* sv/efr_front.sv */
// Input side: decodes each item into an operation and queues it for the back end.
// Depends on efr_pkg.
module efr_front import efr_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  input  efr_in_t in_data,
  output efr_q_t  q,
  input  logic    q_pop
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  efr_qent_t        entry_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r, wr_ptr_nxt, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r;
  logic             push;
  efr_op_t          op_dec;

  assign in_ready = (cnt_r < CNT_W'(QUEUE_DEPTH));
  assign push     = in_valid && in_ready;
  assign op_dec   = in_data.kind ? OP_NEXT : OP_LOAD;

  assign wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
  assign rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;

  assign q.valid = (cnt_r != '0);
  assign q.ent   = entry_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= '{op: op_dec, item: in_data};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_nxt;
      if (q_pop) rd_ptr_r <= rd_ptr_nxt;
      case ({push, q_pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

/* sv/efr_div.sv */
// Restoring divider, one quotient bit per cycle, for 8-bit colour quotients.
// Depends on efr_pkg.
module efr_div import efr_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [NUM_W-1:0]  num,
  input  logic [AREA_W-1:0] den,
  output logic              busy,
  output logic [7:0]        quot
);

  logic [NUM_W-1:0] rem_r, dsh_r;
  logic [7:0]       q_r;
  logic [2:0]       cnt_r;
  logic             busy_r;
  logic             fits;

  assign fits = (rem_r >= dsh_r);
  assign busy = busy_r;
  assign quot = q_r;

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= num;
      dsh_r <= NUM_W'({den, 8'h00});
      q_r   <= '0;
      cnt_r <= '0;
    end else if (busy_r) begin
      if (fits) rem_r <= rem_r - dsh_r;
      q_r   <= {q_r[6:0], fits};
      dsh_r <= dsh_r >> 1;
      cnt_r <= cnt_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (start) begin
      busy_r <= 1'b1;
    end else if (busy_r && cnt_r == 3'd7) begin
      busy_r <= 1'b0;
    end
  end

endmodule

/* sv/efr_back.sv */
// Back end: triangle setup, quad walk, colour interpolation and the result register.
// Depends on efr_pkg and efr_div.
module efr_back import efr_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [CFG_W-1:0] surf_w,
  input  logic [CFG_W-1:0] surf_h,
  input  efr_q_t           q,
  output logic             q_pop,
  output logic             out_valid,
  input  logic             out_ready,
  output efr_out_t         out_data
);

  localparam int SZ_W = (CFG_W > BOX_W) ? CFG_W : BOX_W;
  localparam logic [SZ_W-1:0] SIZE_LIM = SZ_W'((MAX_DIMENSION / 2) * 2);
  localparam logic signed [DIFF_W-1:0] QUAD_SUB = DIFF_W'(2 << SUBPIXEL_BITS);

  function automatic logic [1:0] nxt3(input logic [1:0] i);
    return (i == 2'd2) ? 2'd0 : i + 2'd1;
  endfunction

  function automatic logic [BOX_W-1:0] surf_size(input logic [CFG_W-1:0] reg_v);
    logic [SZ_W-1:0] s;
    s = SZ_W'({reg_v[CFG_W-1:1], 1'b0});
    return (s > SIZE_LIM) ? BOX_W'(SIZE_LIM) : BOX_W'(s);
  endfunction

  // floor to a quad boundary in sub-pixels, then to pixels, clamped to [0, size]
  function automatic logic [BOX_W-1:0] clip_pix(input logic signed [DIFF_W-1:0] sub,
                                                input logic [BOX_W-1:0] size);
    logic signed [DIFF_W-1:0] f;
    logic [DIFF_W-1:0]        p;
    f = {sub[DIFF_W-1:QUAD_LOG], {QUAD_LOG{1'b0}}};
    p = DIFF_W'(unsigned'(f)) >> SUBPIXEL_BITS;
    if (f <= 0) return '0;
    return (p > DIFF_W'(size)) ? size : BOX_W'(p);
  endfunction

  efr_state_t state_r, state_nxt;
  logic [3:0] cnt_r;
  logic signed [COORD_W-1:0] vx_r [3];
  logic signed [COORD_W-1:0] vy_r [3];
  logic [31:0] col_r [3];
  logic signed [PROD_W-1:0] prod_r;
  logic signed [EDGE_W-1:0] acc_r, acc_nxt;
  logic [AREA_W-1:0] dval_r;
  logic [BOX_W-1:0] bx0_r, by0_r, bx1_r, by1_r, cx_r, cy_r, qx_r, qy_r;
  logic signed [STEP_W-1:0] xs_r [3];
  logic signed [STEP_W-1:0] ys_r [3];
  logic [2:0] bias_r;
  logic signed [EDGE_W-1:0] row_r [3];
  logic signed [EDGE_W-1:0] cur_r [3];
  logic active_r;
  logic [AREA_W-1:0] wl_r [4][3];
  logic [3:0] mask_r;
  logic [1:0] lane_r, ch_r, term_r;
  logic [MAC_W-1:0] mac_r, mac_nxt, mac_prod;
  logic [31:0] colq_r [4];
  logic pv_r;
  logic [1:0] pe_r, pt_r;
  efr_status_t status_r;
  logic out_valid_r;
  efr_out_t out_data_r;
  efr_out_t emit_data;

  // shared setup multiplier
  logic signed [MUL_A_W-1:0] ma;
  logic signed [STEP_W-1:0]  mb;
  logic signed [PROD_W-1:0]  mprod;
  logic [1:0] e_sel, ea, eb;

  logic signed [DIFF_W-1:0] dx01, dy20, dy01, dx20;
  logic signed [AREA_W:0]   wgt;
  logic [AREA_W-1:0]        wabs;

  logic signed [COORD_W-1:0] xmin, xmax, ymin, ymax;
  logic [BOX_W-1:0] sw, sh;
  logic [BOX_W-1:0] bx0_c, by0_c, bx1_c, by1_c;
  logic signed [STEP_W-1:0] xs_c [3];
  logic signed [STEP_W-1:0] ys_c [3];
  logic [2:0] bias_c;
  logic [1:0] ia, ib;

  logic signed [EDGE_W-1:0] lw [4][3];
  logic [3:0] cov;

  logic div_start, div_busy;
  logic [7:0] div_q;
  logic [NUM_W-1:0] div_num;

  // ---------------- setup arithmetic ----------------
  always_comb begin
    dx01 = DIFF_W'(vx_r[0]) - DIFF_W'(vx_r[1]);
    dy20 = DIFF_W'(vy_r[2]) - DIFF_W'(vy_r[0]);
    dy01 = DIFF_W'(vy_r[0]) - DIFF_W'(vy_r[1]);
    dx20 = DIFF_W'(vx_r[2]) - DIFF_W'(vx_r[0]);
    e_sel = (cnt_r[3:2] == 2'd3) ? 2'd0 : cnt_r[3:2];
    ea = nxt3(e_sel);
    eb = nxt3(ea);
    ma = '0;
    mb = '0;
    case (state_r)
      S_AREA: begin
        if (cnt_r == 4'd0) begin
          ma = MUL_A_W'(dx01);
          mb = STEP_W'(dy20);
        end else begin
          ma = MUL_A_W'(dy01);
          mb = STEP_W'(dx20);
        end
      end
      S_EDGE: begin
        case (cnt_r[1:0])
          2'd0: begin
            ma = MUL_A_W'(vx_r[eb]);
            mb = STEP_W'(vy_r[ea]);
          end
          2'd1: begin
            ma = MUL_A_W'(vy_r[eb]);
            mb = STEP_W'(vx_r[ea]);
          end
          2'd2: begin
            ma = MUL_A_W'(signed'({1'b0, bx0_r}));
            mb = xs_r[e_sel];
          end
          default: begin
            ma = MUL_A_W'(signed'({1'b0, by0_r}));
            mb = ys_r[e_sel];
          end
        endcase
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
    mprod = PROD_W'(ma) * PROD_W'(mb);
  end

  assign wgt  = (AREA_W + 1)'(acc_r) - (AREA_W + 1)'(prod_r);
  assign wabs = wgt[AREA_W] ? AREA_W'(-wgt) : AREA_W'(wgt);

  always_comb begin
    case (pt_r)
      2'd0:    acc_nxt = EDGE_W'(prod_r);
      2'd1:    acc_nxt = acc_r - EDGE_W'(prod_r);
      default: acc_nxt = acc_r + EDGE_W'(prod_r);
    endcase
  end

  always_comb begin
    xmin = vx_r[0];
    xmax = vx_r[0];
    ymin = vy_r[0];
    ymax = vy_r[0];
    for (int i = 1; i < 3; i++) begin
      if (vx_r[i] < xmin) xmin = vx_r[i];
      if (vx_r[i] > xmax) xmax = vx_r[i];
      if (vy_r[i] < ymin) ymin = vy_r[i];
      if (vy_r[i] > ymax) ymax = vy_r[i];
    end
    sw = surf_size(surf_w);
    sh = surf_size(surf_h);
    bx0_c = clip_pix(DIFF_W'(xmin), sw);
    by0_c = clip_pix(DIFF_W'(ymin), sh);
    bx1_c = clip_pix(DIFF_W'(xmax) + QUAD_SUB, sw);
    by1_c = clip_pix(DIFF_W'(ymax) + QUAD_SUB, sh);
    ia = '0;
    ib = '0;
    for (int i = 0; i < 3; i++) begin
      ia = nxt3(2'(i));
      ib = nxt3(ia);
      xs_c[i] = STEP_W'(DIFF_W'(vy_r[ib]) - DIFF_W'(vy_r[ia])) <<< SUBPIXEL_BITS;
      ys_c[i] = STEP_W'(DIFF_W'(vx_r[ia]) - DIFF_W'(vx_r[ib])) <<< SUBPIXEL_BITS;
      // top edge (flat, heading left) or left edge (heading down) keeps zero bias
      bias_c[i] = !(((vy_r[ia] == vy_r[ib]) && (vx_r[ib] < vx_r[ia]))
                    || (vy_r[ib] > vy_r[ia]));
    end
  end

  // ---------------- quad coverage ----------------
  always_comb begin
    cov = 4'hF;
    for (int l = 0; l < 4; l++) begin
      for (int i = 0; i < 3; i++) begin
        lw[l][i] = cur_r[i]
                 + (l[0] ? EDGE_W'(xs_r[i]) : EDGE_W'(0))
                 + (l[1] ? EDGE_W'(ys_r[i]) : EDGE_W'(0));
        if (bias_r[i] ? (lw[l][i] <= 0) : (lw[l][i] < 0)) cov[l] = 1'b0;
      end
    end
  end

  // ---------------- colour interpolation ----------------
  assign mac_prod = MAC_W'(wl_r[lane_r][term_r]) * MAC_W'(col_r[term_r][{ch_r, 3'b000} +: 8]);
  assign mac_nxt  = ((term_r == 2'd0) ? MAC_W'(0) : mac_r) + mac_prod;
  assign div_num  = {1'b0, mac_r, 1'b0} + NUM_W'(dval_r);

  efr_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (dval_r),
    .busy  (div_busy),
    .quot  (div_q)
  );

  // ---------------- control ----------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (q.valid && !out_valid_r) begin
          if (q.ent.op == OP_LOAD) state_nxt = S_AREA;
          else if (active_r) state_nxt = S_SCAN;
          else state_nxt = S_EMIT;
        end
      end
      S_AREA: begin
        if (cnt_r == 4'd2) state_nxt = (wgt == '0) ? S_EMIT : S_SETUP;
      end
      S_SETUP: state_nxt = S_EDGE;
      S_EDGE: begin
        if (cnt_r == 4'd12) state_nxt = S_EMIT;
      end
      S_SCAN: begin
        if (cy_r >= by1_r) state_nxt = S_EMIT;
        else if (cx_r < bx1_r && cov != 4'h0) state_nxt = S_MAC;
      end
      S_MAC: begin
        if (!mask_r[lane_r]) begin
          if (lane_r == 2'd3) state_nxt = S_EMIT;
        end else if (term_r == 2'd2) begin
          state_nxt = S_DIV_GO;
        end
      end
      S_DIV_GO: state_nxt = S_DIV_WAIT;
      S_DIV_WAIT: begin
        if (!div_busy) begin
          state_nxt = (lane_r == 2'd3 && ch_r == 2'd3) ? S_EMIT : S_MAC;
        end
      end
      S_EMIT: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    q_pop     = (state_r == S_IDLE) && q.valid && !out_valid_r;
    div_start = (state_r == S_DIV_GO);
  end

  // result fields other than status stay zero unless a quad is emitted
  always_comb begin
    emit_data        = '0;
    emit_data.status = status_r;
    if (status_r == STATUS_QUAD) begin
      emit_data.quad_x    = 11'(qx_r);
      emit_data.quad_y    = 11'(qy_r);
      emit_data.coverage  = mask_r;
      emit_data.colour_tl = colq_r[0];
      emit_data.colour_tr = colq_r[1];
      emit_data.colour_bl = colq_r[2];
      emit_data.colour_br = colq_r[3];
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // ---------------- datapath ----------------
  always_ff @(posedge clk) begin
    prod_r <= mprod;
    pe_r   <= e_sel;
    pt_r   <= cnt_r[1:0];
    if (!rst_n) begin
      state_r     <= S_IDLE;
      active_r    <= 1'b0;
      out_valid_r <= 1'b0;
      pv_r        <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pv_r    <= (state_r == S_EDGE) && (cnt_r < 4'd12);
      if (out_valid_r && out_ready) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          cnt_r <= '0;
          if (q_pop) begin
            if (q.ent.op == OP_LOAD) begin
              vx_r[0]  <= q.ent.item.vert0_x;
              vy_r[0]  <= q.ent.item.vert0_y;
              vx_r[1]  <= q.ent.item.vert1_x;
              vy_r[1]  <= q.ent.item.vert1_y;
              vx_r[2]  <= q.ent.item.vert2_x;
              vy_r[2]  <= q.ent.item.vert2_y;
              col_r[0] <= q.ent.item.vert0_colour;
              col_r[1] <= q.ent.item.vert1_colour;
              col_r[2] <= q.ent.item.vert2_colour;
            end else if (!active_r) begin
              status_r <= STATUS_DONE;
            end
          end
        end
        S_AREA: begin
          cnt_r <= cnt_r + 4'd1;
          if (cnt_r == 4'd1) acc_r <= EDGE_W'(prod_r);
          if (cnt_r == 4'd2) begin
            if (wgt == '0) begin
              status_r <= STATUS_CULLED;
              active_r <= 1'b0;
            end else begin
              dval_r <= wabs;
              // clockwise: swap vertices 1 and 2
              if (wgt[AREA_W]) begin
                vx_r[1]  <= vx_r[2];
                vx_r[2]  <= vx_r[1];
                vy_r[1]  <= vy_r[2];
                vy_r[2]  <= vy_r[1];
                col_r[1] <= col_r[2];
                col_r[2] <= col_r[1];
              end
            end
          end
        end
        S_SETUP: begin
          cnt_r  <= '0;
          bx0_r  <= bx0_c;
          by0_r  <= by0_c;
          bx1_r  <= bx1_c;
          by1_r  <= by1_c;
          bias_r <= bias_c;
          for (int i = 0; i < 3; i++) begin
            xs_r[i] <= xs_c[i];
            ys_r[i] <= ys_c[i];
          end
        end
        S_EDGE: begin
          cnt_r <= cnt_r + 4'd1;
          if (pv_r) begin
            acc_r <= acc_nxt;
            if (pt_r == 2'd3) begin
              row_r[pe_r] <= acc_nxt;
              cur_r[pe_r] <= acc_nxt;
            end
          end
          if (cnt_r == 4'd12) begin
            status_r <= STATUS_ACCEPTED;
            active_r <= 1'b1;
            cx_r     <= bx0_r;
            cy_r     <= by0_r;
          end
        end
        S_SCAN: begin
          if (cy_r >= by1_r) begin
            status_r <= STATUS_DONE;
            active_r <= 1'b0;
          end else if (cx_r >= bx1_r) begin
            // advance to the next quad row
            for (int i = 0; i < 3; i++) begin
              row_r[i] <= row_r[i] + (EDGE_W'(ys_r[i]) <<< 1);
              cur_r[i] <= row_r[i] + (EDGE_W'(ys_r[i]) <<< 1);
            end
            cy_r <= cy_r + BOX_W'(2);
            cx_r <= bx0_r;
          end else begin
            for (int i = 0; i < 3; i++) begin
              cur_r[i] <= cur_r[i] + (EDGE_W'(xs_r[i]) <<< 1);
            end
            cx_r <= cx_r + BOX_W'(2);
            if (cov != 4'h0) begin
              status_r <= STATUS_QUAD;
              mask_r   <= cov;
              qx_r     <= cx_r;
              qy_r     <= cy_r;
              lane_r   <= '0;
              ch_r     <= '0;
              term_r   <= '0;
              for (int l = 0; l < 4; l++) begin
                colq_r[l] <= '0;
                for (int i = 0; i < 3; i++) begin
                  wl_r[l][i] <= AREA_W'(lw[l][i]);
                end
              end
            end
          end
        end
        S_MAC: begin
          if (!mask_r[lane_r]) begin
            lane_r <= lane_r + 2'd1;
            ch_r   <= '0;
            term_r <= '0;
          end else begin
            mac_r  <= mac_nxt;
            term_r <= (term_r == 2'd2) ? 2'd0 : term_r + 2'd1;
          end
        end
        S_DIV_WAIT: begin
          if (!div_busy) begin
            colq_r[lane_r][{ch_r, 3'b000} +: 8] <= div_q;
            term_r <= '0;
            if (ch_r == 2'd3) begin
              ch_r   <= '0;
              lane_r <= lane_r + 2'd1;
            end else begin
              ch_r <= ch_r + 2'd1;
            end
          end
        end
        S_EMIT: begin
          out_valid_r <= 1'b1;
          out_data_r  <= emit_data;
        end
        default: begin
          cnt_r <= cnt_r;
        end
      endcase
    end
  end

endmodule

/* sv/edge_function_triangle_rasterizer.sv */
// Edge-function triangle rasterizer, walked one 2x2 pixel quad per request.
//
// Usage:
//   in_*  : valid/ready channel. kind 0 loads a triangle (12.4 vertices, RGBA8
//           colours), kind 1 asks for the next covered quad of that triangle.
//   out_* : valid/ready channel, exactly one result per input item:
//           accepted, culled, quad (coverage plus four colours) or done.
//   cfg_* : write-only registers, index 0 surface width, 1 surface height;
//           sampled at each triangle load.
// A load computes the area, then the bounding box and steps, then the edge
// start values on the shared setup multiplier.
// A next request tests quads one at a time and advances at each row end; per
// covered pixel each of 4 channels takes 3 multiply-accumulate steps, a start
// and the bit-serial divider, and each uncovered lane is skipped.
// A two-entry input queue keeps accepting items while the back end works or
// a result waits; the back end takes the next item only after the result
// register has been emptied, so a stalled receiver holds the result and the
// queue fills. Reset (synchronous, active low) empties the queue and the
// result register, drops any active triangle and sets 640x480.
// Depends on efr_pkg, efr_front, efr_back.
module edge_function_triangle_rasterizer import efr_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  efr_in_t              in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output efr_out_t             out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  logic [CFG_W-1:0] surf_w_r, surf_h_r;
  efr_q_t           q;
  logic             q_pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      surf_w_r <= SURF_W_RESET;
      surf_h_r <= SURF_H_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_IDX_WIDTH:  surf_w_r <= cfg_wdata;
        CFG_IDX_HEIGHT: surf_h_r <= cfg_wdata;
        default:        surf_w_r <= surf_w_r;
      endcase
    end
  end

  efr_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q        (q),
    .q_pop    (q_pop)
  );

  efr_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .surf_w    (surf_w_r),
    .surf_h    (surf_h_r),
    .q         (q),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

/* sv/efr_chk.sv */
// Port-level checks for the rasterizer, attached to the top level by bind.
// Depends on efr_pkg and edge_function_triangle_rasterizer.
module efr_chk import efr_pkg::*; (
  input logic     clk,
  input logic     rst_n,
  input logic     in_valid,
  input logic     in_ready,
  input logic     out_valid,
  input logic     out_ready,
  input efr_out_t out_data
);

  logic [2:0] pend_r;
  logic       in_acc, out_acc;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  // items taken but not yet answered
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      case ({in_acc, out_acc})
        2'b10:   pend_r <= pend_r + 3'd1;
        2'b01:   pend_r <= pend_r - 3'd1;
        default: pend_r <= pend_r;
      endcase
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pend_r != 3'd0)
    else $error("result without a pending item");

  a_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r <= 3'd3)
    else $error("more items in flight than queue and back end hold");

  a_quad: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == STATUS_QUAD |->
      out_data.coverage != 4'h0
      && (out_data.coverage[0] || out_data.colour_tl == 32'h0)
      && (out_data.coverage[3] || out_data.colour_br == 32'h0))
    else $error("quad result with bad coverage or colour");

  a_plain: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != STATUS_QUAD |->
      out_data.coverage == 4'h0 && out_data.quad_x == 11'h0
      && out_data.colour_tl == 32'h0)
    else $error("non-quad result carries quad fields");

endmodule

bind edge_function_triangle_rasterizer efr_chk u_efr_chk (.*);
